@@ sv/gbk2u_pkg.sv @@
// Shared constants, field layout and control types for the GBK to UTF-8 transcoder.
// No dependencies; every other file except gbk2u_ram refers to it by scoped names.
package gbk2u_pkg;

  // Mapping store geometry
  localparam int TABLE_DEPTH = 8192;
  localparam int ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W       = ADDR_W + 1;
  localparam int SUM_W       = CNT_W + 1;
  localparam int ENTRY_W     = 32;

  // Field widths
  localparam int CFG_W  = 14;
  localparam int IDX_W  = 13;
  localparam int CODE_W = 16;
  localparam int BYTE_W = 8;

  // Input tdata layout, lowest field first
  localparam int IDX_LSB  = 0;
  localparam int GBK_LSB  = IDX_LSB + IDX_W;
  localparam int UNI_LSB  = GBK_LSB + CODE_W;
  localparam int BYTE_LSB = UNI_LSB + CODE_W;
  localparam int IN_DATA_W = ((BYTE_LSB + BYTE_W + 7) / 8) * 8;

  // Item kinds carried in tuser
  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_TEXT = 1'b1;

  // Byte classes
  localparam logic [7:0] ASCII_LIMIT = 8'h80;
  localparam logic [7:0] PAIR_LOW    = 8'hA1;
  localparam logic [7:0] PAIR_HIGH   = 8'hFE;

  // UTF-8 encoding
  localparam logic [15:0] ONE_BYTE_MAX = 16'h007F;
  localparam logic [15:0] TWO_BYTE_MAX = 16'h07FF;
  localparam logic [7:0]  LEAD2        = 8'hC0;
  localparam logic [7:0]  LEAD3        = 8'hE0;
  localparam logic [7:0]  CONT         = 8'h80;
  localparam logic [7:0]  BOX_B0       = 8'hE2;
  localparam logic [7:0]  BOX_B1       = 8'h96;
  localparam logic [7:0]  BOX_B2       = 8'hA1;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SEARCH = 4'b0010,
    ST_ENCODE = 4'b0100,
    ST_EMIT   = 4'b1000
  } state_t;

  typedef struct packed {
    logic take;         // item accepted this cycle
    logic search_step;  // compare the probe just read and move the bounds
    logic encode;       // turn the found code point into output bytes
    logic pop;          // one output byte taken
  } cmd_t;

  typedef struct packed {
    logic need_search;  // accepted item starts a table search
    logic need_encode;  // accepted item pairs up but the search range is empty
    logic has_output;   // accepted item produces bytes at once
    logic search_done;  // probe matched or the range closed
    logic emit_last;    // byte on the output is the final one of its run
  } status_t;

endpackage

@@ sv/gbk_to_utf8_transcoder_core.sv @@
// Top level of the GBK to UTF-8 transcoder: stream ports, controller and datapath.
// Depends on gbk2u_pkg, gbk2u_ctrl, gbk2u_dp (and through it gbk2u_ram).
//
//  Channel | Direction | Handshake           | Contents
//  in_     | slave     | in_tvalid/in_tready | load entry or text byte
//  out_    | master    | out_tvalid/out_tready | one output byte
//  cfg_    | slave     | cfg_valid/cfg_ready | entries_in_use
//
// One item at a time. A load item or a held lead byte is done once accepted; a passed or
// raw byte is accepted and then sent out one output byte at a time. A mapped pair is
// accepted, searched one probe at a time as the store has a single read port (at most
// log2 of the store depth plus one probes), encoded, and sent out as one to three bytes.
// Reset clears the pending lead, the register and the controller; the store is not
// cleared. A stalled output holds its byte and the input stays not ready.
module gbk_to_utf8_transcoder_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // entry_index[12:0], entry_gbk[28:13], entry_unicode[44:29], in_byte[52:45], zero fill
  input  logic [gbk2u_pkg::IN_DATA_W-1:0]     in_tdata,
  input  logic                                in_tuser,   // func
  input  logic                                in_tlast,   // end_of_text
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [gbk2u_pkg::BYTE_W-1:0]        out_tdata,  // out_byte[7:0]
  output logic                                out_tuser,  // replacement
  output logic                                out_tlast,  // last_of_run
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [gbk2u_pkg::CFG_W-1:0]         cfg_data
);

  gbk2u_pkg::cmd_t    cmd;
  gbk2u_pkg::status_t st;

  assign cfg_ready = 1'b1;

  gbk2u_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .st         (st),
    .cmd        (cmd)
  );

  gbk2u_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_write    (cfg_valid && cfg_ready),
    .cfg_data     (cfg_data),
    .item_func    (in_tuser),
    .item_index   (in_tdata[gbk2u_pkg::IDX_LSB +: gbk2u_pkg::IDX_W]),
    .item_gbk     (in_tdata[gbk2u_pkg::GBK_LSB +: gbk2u_pkg::CODE_W]),
    .item_unicode (in_tdata[gbk2u_pkg::UNI_LSB +: gbk2u_pkg::CODE_W]),
    .item_byte    (in_tdata[gbk2u_pkg::BYTE_LSB +: gbk2u_pkg::BYTE_W]),
    .item_end     (in_tlast),
    .cmd          (cmd),
    .st           (st),
    .res_byte     (out_tdata),
    .res_last     (out_tlast),
    .res_repl     (out_tuser)
  );

endmodule

@@ sv/gbk2u_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module gbk2u_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8192
) (
  input  logic                                       clk,
  input  logic                                       wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                           wr_data,
  input  logic                                       rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                           rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ sv/gbk2u_ctrl.sv @@
// Controller state machine: sequences accept, table search, encode and byte output.
// Depends on gbk2u_pkg for the state, command and status types.
module gbk2u_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  output logic                out_tvalid,
  input  logic                out_tready,
  input  gbk2u_pkg::status_t  st,
  output gbk2u_pkg::cmd_t     cmd
);

  gbk2u_pkg::state_t state_r, state_nxt;

  always_comb begin
    in_tready       = (state_r == gbk2u_pkg::ST_IDLE);
    out_tvalid      = (state_r == gbk2u_pkg::ST_EMIT);
    cmd.take        = in_tready && in_tvalid;
    cmd.search_step = (state_r == gbk2u_pkg::ST_SEARCH);
    cmd.encode      = (state_r == gbk2u_pkg::ST_ENCODE);
    cmd.pop         = out_tvalid && out_tready;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      gbk2u_pkg::ST_IDLE: begin
        if (cmd.take) begin
          priority if (st.need_search) state_nxt = gbk2u_pkg::ST_SEARCH;
          else if (st.need_encode)     state_nxt = gbk2u_pkg::ST_ENCODE;
          else if (st.has_output)      state_nxt = gbk2u_pkg::ST_EMIT;
          else                         state_nxt = gbk2u_pkg::ST_IDLE;
        end
      end
      gbk2u_pkg::ST_SEARCH: begin
        if (st.search_done) state_nxt = gbk2u_pkg::ST_ENCODE;
      end
      gbk2u_pkg::ST_ENCODE: begin
        state_nxt = gbk2u_pkg::ST_EMIT;
      end
      gbk2u_pkg::ST_EMIT: begin
        if (cmd.pop && st.emit_last) state_nxt = gbk2u_pkg::ST_IDLE;
      end
      default: state_nxt = gbk2u_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= gbk2u_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

@@ sv/gbk2u_dp.sv @@
// Datapath: pending lead byte, mapping store, binary search bounds, UTF-8 encoder
// and three-byte output buffer. Depends on gbk2u_pkg and gbk2u_ram.
module gbk2u_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_write,
  input  logic [gbk2u_pkg::CFG_W-1:0]         cfg_data,
  input  logic                                item_func,
  input  logic [gbk2u_pkg::IDX_W-1:0]         item_index,
  input  logic [gbk2u_pkg::CODE_W-1:0]        item_gbk,
  input  logic [gbk2u_pkg::CODE_W-1:0]        item_unicode,
  input  logic [gbk2u_pkg::BYTE_W-1:0]        item_byte,
  input  logic                                item_end,
  input  gbk2u_pkg::cmd_t                     cmd,
  output gbk2u_pkg::status_t                  st,
  output logic [gbk2u_pkg::BYTE_W-1:0]        res_byte,
  output logic                                res_last,
  output logic                                res_repl
);

  // Configuration
  logic [gbk2u_pkg::CFG_W-1:0] entries_r;

  // Pending lead byte
  logic                          pend_valid_r, pend_valid_nxt;
  logic [gbk2u_pkg::BYTE_W-1:0]  pend_lead_r, pend_lead_nxt;

  // Search state
  logic [gbk2u_pkg::CODE_W-1:0]  code_r, code_nxt;
  logic [gbk2u_pkg::CNT_W-1:0]   lo_r, lo_nxt, hi_r, hi_nxt;
  logic [gbk2u_pkg::ADDR_W-1:0]  mid_r, mid_nxt;
  logic [gbk2u_pkg::CODE_W-1:0]  u_r, u_nxt;

  // Output buffer
  logic [gbk2u_pkg::BYTE_W-1:0]  buf_byte_r [3];
  logic [gbk2u_pkg::BYTE_W-1:0]  buf_byte_nxt [3];
  logic [2:0]                    buf_repl_r, buf_repl_nxt;
  logic [1:0]                    buf_cnt_r, buf_cnt_nxt;
  logic [1:0]                    buf_idx_r, buf_idx_nxt;

  // Store access
  logic                            wr_en;
  logic [gbk2u_pkg::ENTRY_W-1:0]   rd_data;

  // Combinational helpers
  logic                          is_text, b_ascii_or_end, lead_ok, b_ok, pair_ok;
  logic [gbk2u_pkg::CNT_W-1:0]   n_clamp;
  logic [gbk2u_pkg::SUM_W-1:0]   sum0, sum_n;
  logic [gbk2u_pkg::CNT_W-1:0]   lo_n, hi_n;
  logic [gbk2u_pkg::ADDR_W-1:0]  mid0, mid_n;
  logic [gbk2u_pkg::CODE_W-1:0]  probe_gbk;
  logic                          hit, probe_lt, range_closed;

  gbk2u_ram #(
    .WIDTH (gbk2u_pkg::ENTRY_W),
    .DEPTH (gbk2u_pkg::TABLE_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (item_index[gbk2u_pkg::ADDR_W-1:0]),
    .wr_data ({item_gbk, item_unicode}),
    .rd_en   (1'b1),
    .rd_addr (mid_nxt),
    .rd_data (rd_data)
  );

  always_comb begin
    is_text        = (item_func == gbk2u_pkg::FUNC_TEXT);
    wr_en          = cmd.take && !is_text &&
                     ({1'b0, item_index} < (gbk2u_pkg::IDX_W + 1)'(gbk2u_pkg::TABLE_DEPTH));
    b_ascii_or_end = (item_byte < gbk2u_pkg::ASCII_LIMIT) || item_end;
    lead_ok        = (pend_lead_r >= gbk2u_pkg::PAIR_LOW) &&
                     (pend_lead_r <= gbk2u_pkg::PAIR_HIGH);
    b_ok           = (item_byte >= gbk2u_pkg::PAIR_LOW) &&
                     (item_byte <= gbk2u_pkg::PAIR_HIGH);
    pair_ok        = pend_valid_r && lead_ok && b_ok;

    // Limit the search to the store depth
    if (entries_r > gbk2u_pkg::CNT_W'(gbk2u_pkg::TABLE_DEPTH)) begin
      n_clamp = gbk2u_pkg::CNT_W'(gbk2u_pkg::TABLE_DEPTH);
    end else begin
      n_clamp = entries_r;
    end
    sum0 = {1'b0, n_clamp} - gbk2u_pkg::SUM_W'(1);
    mid0 = sum0[gbk2u_pkg::ADDR_W:1];

    // One probe: read data belongs to mid_r
    probe_gbk = rd_data[gbk2u_pkg::ENTRY_W-1 -: gbk2u_pkg::CODE_W];
    hit       = (probe_gbk == code_r);
    probe_lt  = (probe_gbk < code_r);
    lo_n      = probe_lt ? ({1'b0, mid_r} + gbk2u_pkg::CNT_W'(1)) : lo_r;
    hi_n      = probe_lt ? hi_r : {1'b0, mid_r};
    range_closed = (lo_n >= hi_n);
    sum_n     = {1'b0, lo_n} + {1'b0, hi_n} - gbk2u_pkg::SUM_W'(1);
    mid_n     = sum_n[gbk2u_pkg::ADDR_W:1];
  end

  always_comb begin
    pend_valid_nxt = pend_valid_r;
    pend_lead_nxt  = pend_lead_r;
    code_nxt       = code_r;
    lo_nxt         = lo_r;
    hi_nxt         = hi_r;
    mid_nxt        = mid_r;
    u_nxt          = u_r;
    buf_byte_nxt   = buf_byte_r;
    buf_repl_nxt   = buf_repl_r;
    buf_cnt_nxt    = buf_cnt_r;
    buf_idx_nxt    = buf_idx_r;

    st.need_search = 1'b0;
    st.need_encode = 1'b0;
    st.has_output  = 1'b0;
    st.search_done = hit || range_closed;
    st.emit_last   = (buf_idx_r == (buf_cnt_r - 2'd1));

    if (cmd.take && is_text) begin
      buf_idx_nxt  = 2'd0;
      buf_repl_nxt = 3'b000;
      if (!pend_valid_r) begin
        if (b_ascii_or_end) begin
          buf_byte_nxt[0] = item_byte;
          buf_cnt_nxt     = 2'd1;
          st.has_output   = 1'b1;
        end else begin
          pend_valid_nxt = 1'b1;
          pend_lead_nxt  = item_byte;
        end
      end else if (pair_ok) begin
        pend_valid_nxt = 1'b0;
        code_nxt       = {pend_lead_r, item_byte};
        lo_nxt         = '0;
        hi_nxt         = n_clamp;
        mid_nxt        = mid0;
        if (n_clamp == '0) begin
          u_nxt          = '0;
          st.need_encode = 1'b1;
        end else begin
          st.need_search = 1'b1;
        end
      end else begin
        // Emit the lead raw, then treat the second byte as fresh
        buf_byte_nxt[0] = pend_lead_r;
        st.has_output   = 1'b1;
        if (b_ascii_or_end) begin
          pend_valid_nxt  = 1'b0;
          buf_byte_nxt[1] = item_byte;
          buf_cnt_nxt     = 2'd2;
        end else begin
          pend_valid_nxt = 1'b1;
          pend_lead_nxt  = item_byte;
          buf_cnt_nxt    = 2'd1;
        end
      end
    end

    if (cmd.search_step) begin
      lo_nxt  = lo_n;
      hi_nxt  = hi_n;
      mid_nxt = mid_n;
      if (hit) begin
        u_nxt = rd_data[gbk2u_pkg::CODE_W-1:0];
      end else if (range_closed) begin
        u_nxt = '0;
      end
    end

    if (cmd.encode) begin
      buf_idx_nxt = 2'd0;
      priority if (u_r == '0) begin
        buf_byte_nxt[0] = gbk2u_pkg::BOX_B0;
        buf_byte_nxt[1] = gbk2u_pkg::BOX_B1;
        buf_byte_nxt[2] = gbk2u_pkg::BOX_B2;
        buf_repl_nxt    = 3'b111;
        buf_cnt_nxt     = 2'd3;
      end else if (u_r <= gbk2u_pkg::ONE_BYTE_MAX) begin
        buf_byte_nxt[0] = u_r[7:0];
        buf_repl_nxt    = 3'b000;
        buf_cnt_nxt     = 2'd1;
      end else if (u_r <= gbk2u_pkg::TWO_BYTE_MAX) begin
        buf_byte_nxt[0] = gbk2u_pkg::LEAD2 | {3'b000, u_r[10:6]};
        buf_byte_nxt[1] = gbk2u_pkg::CONT | {2'b00, u_r[5:0]};
        buf_repl_nxt    = 3'b000;
        buf_cnt_nxt     = 2'd2;
      end else begin
        buf_byte_nxt[0] = gbk2u_pkg::LEAD3 | {4'b0000, u_r[15:12]};
        buf_byte_nxt[1] = gbk2u_pkg::CONT | {2'b00, u_r[11:6]};
        buf_byte_nxt[2] = gbk2u_pkg::CONT | {2'b00, u_r[5:0]};
        buf_repl_nxt    = 3'b000;
        buf_cnt_nxt     = 2'd3;
      end
    end

    if (cmd.pop) begin
      buf_idx_nxt = buf_idx_r + 2'd1;
    end
  end

  always_comb begin
    res_byte = buf_byte_r[buf_idx_r];
    res_repl = buf_repl_r[buf_idx_r];
    res_last = st.emit_last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entries_r    <= '0;
      pend_valid_r <= 1'b0;
      pend_lead_r  <= '0;
      buf_cnt_r    <= 2'd0;
      buf_idx_r    <= 2'd0;
    end else begin
      if (cfg_write) begin
        entries_r <= cfg_data;
      end
      pend_valid_r <= pend_valid_nxt;
      pend_lead_r  <= pend_lead_nxt;
      buf_cnt_r    <= buf_cnt_nxt;
      buf_idx_r    <= buf_idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    code_r     <= code_nxt;
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    mid_r      <= mid_nxt;
    u_r        <= u_nxt;
    buf_byte_r <= buf_byte_nxt;
    buf_repl_r <= buf_repl_nxt;
  end

endmodule
